// ===== sv/hsvrgb_pkg.sv =====
package hsvrgb_pkg;

  // Field widths
  localparam int HueW   = 16;
  localparam int ChanW  = 8;
  localparam int FracW  = 10;
  localparam int SectW  = 3;
  localparam int QuotW  = 7;
  localparam int WeightSumW = 18;
  localparam int ScaledW    = 26;
  localparam int DivInW     = 20;

  // One 60-degree sector in 1/16-degree units; full-scale channel weight
  localparam logic [FracW-1:0] HueSector = 10'd960;

  // hue / 960 == (hue >> 6) / 15, done as a multiply by a reciprocal
  localparam int SectorPreShift = 6;
  localparam logic [10:0] SectorRecip = 11'd1093;
  localparam int SectorRecipShift = 14;

  // q / 6 for q below 69
  localparam logic [5:0] SixRecip = 6'd43;
  localparam int SixRecipShift = 8;
  localparam logic [2:0] SectorsPerTurn = 3'd6;

  // Channel scale: round(v * a / 244800), 244800 = 255 * 960 = 64 * 3825
  localparam logic [7:0]  FullScale   = 8'd255;
  localparam logic [16:0] RoundHalf   = 17'd122400;
  localparam int          DivPreShift = 6;
  localparam logic [20:0] DivRecip    = 21'd1122868;
  localparam int          DivRecipShift = 32;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_SATURATION = 1'b0,
    REG_BRIGHTNESS = 1'b1
  } reg_index_t;

  // Load enables for the per-channel stages
  typedef struct packed {
    logic weight;
    logic scale;
    logic quot;
  } stage_en_t;

endpackage

// ===== sv/hsvrgb_chan.sv =====
module hsvrgb_chan (
  input  logic                                     clk,
  input  hsvrgb_pkg::stage_en_t                    en,
  input  logic [hsvrgb_pkg::FracW-1:0]             weight,
  input  logic [hsvrgb_pkg::ChanW-1:0]             saturation,
  input  logic [hsvrgb_pkg::ChanW-1:0]             brightness,
  output logic [hsvrgb_pkg::ChanW-1:0]             level
);

  logic [hsvrgb_pkg::WeightSumW-1:0] wsum;
  logic [hsvrgb_pkg::WeightSumW-1:0] wsum_next;
  logic [hsvrgb_pkg::ScaledW-1:0]    scaled_next;
  logic [hsvrgb_pkg::DivInW-1:0]     div_in;
  logic [hsvrgb_pkg::DivInW-1:0]     div_in_next;
  logic [40:0]                       prod;

  // Blend chroma weight with the gray floor: s*g + (255-s)*960
  always_comb begin
    wsum_next = hsvrgb_pkg::WeightSumW'(saturation * weight)
              + hsvrgb_pkg::WeightSumW'((hsvrgb_pkg::FullScale - saturation)
                                        * hsvrgb_pkg::HueSector);
  end

  // Scale by value and add half a step for rounding; drop the power-of-two factor
  always_comb begin
    scaled_next = hsvrgb_pkg::ScaledW'(brightness * wsum)
                + hsvrgb_pkg::ScaledW'(hsvrgb_pkg::RoundHalf);
    div_in_next = scaled_next[hsvrgb_pkg::ScaledW-1:hsvrgb_pkg::DivPreShift];
  end

  // Divide by 3825 through the reciprocal
  assign prod = 41'(div_in * hsvrgb_pkg::DivRecip);

  always_ff @(posedge clk) begin
    if (en.weight) begin
      wsum <= wsum_next;
    end
    if (en.scale) begin
      div_in <= div_in_next;
    end
    if (en.quot) begin
      level <= prod[hsvrgb_pkg::DivRecipShift+hsvrgb_pkg::ChanW-1:
                    hsvrgb_pkg::DivRecipShift];
    end
  end

endmodule

// ===== sv/hsv_to_rgb_color_core.sv =====
// Hue to RGB converter with fixed saturation and brightness. Each transfer on
// the hue channel (1/16-degree units, any 16-bit value, wrapped at 360 degrees)
// yields one transfer of red, green and blue, each rounded to nearest 0..255.
// The block takes one hue every clock while the color side does not stall,
// and passes it through a five-stage pipeline (sector split, sector select,
// weight blend, value scale, reciprocal divide); stalls on the color side back
// up stage by stage and free stages keep filling. Write saturation and
// brightness only while no hue is in flight; both reset to 204.
module hsv_to_rgb_color_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr_en,
  input  logic [0:0]                         wr_index,
  input  logic [hsvrgb_pkg::ChanW-1:0]       wr_data,
  input  logic                               hue_valid,
  output logic                               hue_stall,
  input  logic [hsvrgb_pkg::HueW-1:0]        hue,
  output logic                               rgb_valid,
  input  logic                               rgb_stall,
  output logic [hsvrgb_pkg::ChanW-1:0]       red,
  output logic [hsvrgb_pkg::ChanW-1:0]       green,
  output logic [hsvrgb_pkg::ChanW-1:0]       blue
);

  logic [hsvrgb_pkg::ChanW-1:0] saturation;
  logic [hsvrgb_pkg::ChanW-1:0] brightness;

  // Stage valids and ready chain
  logic v1, v2, v3, v4, v5;
  logic r1, r2, r3, r4, r5;

  // Stage 1: hue and its 60-degree count
  logic [hsvrgb_pkg::HueW-1:0]  hue1;
  logic [hsvrgb_pkg::QuotW-1:0] cnt1;
  logic [20:0]                  cnt_prod;

  // Stage 2: sector and position within it
  logic [hsvrgb_pkg::SectW-1:0] sector2;
  logic [hsvrgb_pkg::FracW-1:0] frac2;
  logic [12:0]                  six_prod;
  logic [3:0]                   turns;
  logic [hsvrgb_pkg::SectW-1:0] sector_next;
  logic [hsvrgb_pkg::HueW-1:0]  base_next;
  logic [hsvrgb_pkg::HueW-1:0]  frac_full;

  logic [hsvrgb_pkg::FracW-1:0] g_red, g_green, g_blue;
  logic [hsvrgb_pkg::FracW-1:0] rise, fall;

  hsvrgb_pkg::stage_en_t en;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      saturation <= 8'd204;
      brightness <= 8'd204;
    end else if (wr_en) begin
      if (wr_index == hsvrgb_pkg::REG_SATURATION) begin
        saturation <= wr_data;
      end else if (wr_index == hsvrgb_pkg::REG_BRIGHTNESS) begin
        brightness <= wr_data;
      end
    end
  end

  // A stage loads when empty or when the next one moves on
  assign r5 = !v5 || !rgb_stall;
  assign r4 = !v4 || r5;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign hue_stall = !r1;
  assign rgb_valid = v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (r1) v1 <= hue_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
      if (r5) v5 <= v4;
    end
  end

  // Count whole sectors: hue / 960
  assign cnt_prod = 21'(hue[hsvrgb_pkg::HueW-1:hsvrgb_pkg::SectorPreShift]
                        * hsvrgb_pkg::SectorRecip);

  always_ff @(posedge clk) begin
    if (r1) begin
      hue1 <= hue;
      cnt1 <= cnt_prod[hsvrgb_pkg::SectorRecipShift+hsvrgb_pkg::QuotW-1:
                       hsvrgb_pkg::SectorRecipShift];
    end
  end

  // Reduce the sector count modulo six and take the remainder position
  always_comb begin
    six_prod    = 13'(cnt1 * hsvrgb_pkg::SixRecip);
    turns       = six_prod[hsvrgb_pkg::SixRecipShift+3:hsvrgb_pkg::SixRecipShift];
    sector_next = hsvrgb_pkg::SectW'(cnt1 - hsvrgb_pkg::QuotW'(turns
                                     * hsvrgb_pkg::SectorsPerTurn));
    base_next   = hsvrgb_pkg::HueW'(cnt1 * hsvrgb_pkg::HueSector);
    frac_full   = hue1 - base_next;
  end

  always_ff @(posedge clk) begin
    if (r2) begin
      sector2 <= sector_next;
      frac2   <= frac_full[hsvrgb_pkg::FracW-1:0];
    end
  end

  // Assign full, rising, falling or zero weight to each channel
  always_comb begin
    rise = frac2;
    fall = hsvrgb_pkg::HueSector - frac2;
    case (sector2)
      3'd0: begin
        g_red = hsvrgb_pkg::HueSector; g_green = rise; g_blue = '0;
      end
      3'd1: begin
        g_red = fall; g_green = hsvrgb_pkg::HueSector; g_blue = '0;
      end
      3'd2: begin
        g_red = '0; g_green = hsvrgb_pkg::HueSector; g_blue = rise;
      end
      3'd3: begin
        g_red = '0; g_green = fall; g_blue = hsvrgb_pkg::HueSector;
      end
      3'd4: begin
        g_red = rise; g_green = '0; g_blue = hsvrgb_pkg::HueSector;
      end
      default: begin
        g_red = hsvrgb_pkg::HueSector; g_green = '0; g_blue = fall;
      end
    endcase
  end

  assign en.weight = r3;
  assign en.scale  = r4;
  assign en.quot   = r5;

  hsvrgb_chan u_red (
    .clk        (clk),
    .en         (en),
    .weight     (g_red),
    .saturation (saturation),
    .brightness (brightness),
    .level      (red)
  );

  hsvrgb_chan u_green (
    .clk        (clk),
    .en         (en),
    .weight     (g_green),
    .saturation (saturation),
    .brightness (brightness),
    .level      (green)
  );

  hsvrgb_chan u_blue (
    .clk        (clk),
    .en         (en),
    .weight     (g_blue),
    .saturation (saturation),
    .brightness (brightness),
    .level      (blue)
  );

endmodule
